// ===== src/ohr_pkg.sv =====
// Shared types and constants for the overwrite history ring.
// No dependencies; used by every module in src except ohr_ram.
package ohr_pkg;

	localparam int DEPTH_DEF       = 32;
	localparam int RECORD_BITS_DEF = 64;
	localparam int STEP_LIMIT      = 50;
	localparam int WALK_W          = $clog2(STEP_LIMIT + 1);
	localparam int CNT_W           = 5;
	localparam int REC_W           = 64;
	localparam int IN_TDATA_W      = 80;
	localparam int OUT_TDATA_W     = 72;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic add;
		logic clear;
		logic start;
		logic step;
		logic null_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic step_done;
		logic step_any;
		logic pending;
		logic load;
		logic out_free;
	} status_t;

endpackage

// ===== src/ohr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ohr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ohr_datapath.sv =====
// Datapath: ring pointers, slot RAM, read walk counters and output register.
// Depends on ohr_pkg and ohr_ram.
module ohr_datapath #(
	parameter int DEPTH       = ohr_pkg::DEPTH_DEF,
	parameter int RECORD_BITS = ohr_pkg::RECORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ohr_pkg::cmd_t                  cmd,
	output ohr_pkg::status_t               status,
	input  logic [ohr_pkg::IN_TDATA_W-1:0] in_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ohr_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	output logic                           m_tuser
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int WALK_W = ohr_pkg::WALK_W;
	localparam int CNT_W  = ohr_pkg::CNT_W;
	localparam int REC_W  = ohr_pkg::REC_W;

	logic [IDX_W-1:0]       oldest_q, next_free_q, pos_q;
	logic [WALK_W-1:0]      walk_q;
	logic [CNT_W-1:0]       n_q, skip_q, want_q, room_q;
	logic                   pending_s1, last_s1;
	logic [CNT_W-1:0]       position_s1;
	logic [RECORD_BITS-1:0] rdata;
	logic [REC_W-1:0]       rec_q;
	logic [CNT_W-1:0]       pos_out_q;
	logic                   found_q;

	logic [IDX_W-1:0] free_inc, oldest_inc, addr;
	logic             full, emit, cont, load, out_free;
	logic [CNT_W-1:0] n_next;

	always_comb begin
		free_inc   = (next_free_q == IDX_W'(DEPTH - 1)) ? '0 : next_free_q + IDX_W'(1);
		oldest_inc = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);
		full       = (free_inc == oldest_q);
		addr       = (pos_q == '0) ? IDX_W'(DEPTH - 1) : pos_q - IDX_W'(1);
		emit       = (walk_q >= WALK_W'(skip_q)) && (n_q < room_q) && (n_q < want_q);
		n_next     = n_q + CNT_W'(emit);
		cont       = (addr != oldest_q)
			&& ((walk_q + WALK_W'(1)) < WALK_W'(ohr_pkg::STEP_LIMIT))
			&& (n_next < room_q) && (n_next < want_q);
		out_free   = !m_tvalid || m_tready;
		load       = pending_s1 && out_free;
	end

	assign status.empty     = (oldest_q == next_free_q);
	assign status.step_done = !cont;
	assign status.step_any  = (n_next != '0);
	assign status.pending   = pending_s1;
	assign status.load      = load;
	assign status.out_free  = out_free;

	ohr_ram #(
		.WIDTH(RECORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.add),
		.waddr(next_free_q),
		.wdata(in_data[RECORD_BITS-1:0]),
		.re   (cmd.step),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			next_free_q <= '0;
			pending_s1  <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (cmd.add) begin
				if (full) begin
					oldest_q <= oldest_inc;
				end
				next_free_q <= free_inc;
			end
			if (cmd.clear) begin
				oldest_q <= next_free_q;
			end
			if (cmd.step) begin
				pending_s1 <= emit;
			end else if (load) begin
				pending_s1 <= 1'b0;
			end
			if (load || cmd.null_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q  <= next_free_q;
			walk_q <= '0;
			n_q    <= '0;
			skip_q <= in_data[68:64];
			want_q <= in_data[73:69];
			room_q <= in_data[78:74];
		end
		if (cmd.step) begin
			pos_q       <= addr;
			walk_q      <= walk_q + WALK_W'(1);
			n_q         <= n_next;
			position_s1 <= n_q;
			last_s1     <= !cont;
		end
		if (load) begin
			rec_q     <= REC_W'(rdata);
			pos_out_q <= position_s1;
			m_tlast   <= last_s1;
			found_q   <= 1'b1;
		end else if (cmd.null_load) begin
			rec_q     <= '0;
			pos_out_q <= '0;
			m_tlast   <= 1'b1;
			found_q   <= 1'b0;
		end
	end

	assign m_tdata = {3'b000, pos_out_q, rec_q};
	assign m_tuser = found_q;

endmodule

// ===== src/ohr_ctrl.sv =====
// Controller: decodes items and sequences the newest-first read walk.
// Depends on ohr_pkg.
module ohr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [1:0]             op,
	input  ohr_pkg::status_t       status,
	output ohr_pkg::cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_NULL
	} state_t;

	state_t state_q;
	logic   take, can_step, can_null;

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		take          = s_tvalid && s_tready;
		can_step      = (state_q == ST_WALK) && (!status.pending || status.load);
		can_null      = (state_q == ST_NULL) && !status.pending && status.out_free;
		cmd.add       = take && (op == ohr_pkg::OP_ADD);
		cmd.clear     = take && (op == ohr_pkg::OP_CLEAR);
		cmd.start     = take && (op == ohr_pkg::OP_READ);
		cmd.step      = can_step;
		cmd.null_load = can_null;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= status.empty ? ST_NULL : ST_WALK;
					end
				end
				ST_WALK: begin
					if (can_step && status.step_done) begin
						state_q <= status.step_any ? ST_IDLE : ST_NULL;
					end
				end
				ST_NULL: begin
					if (can_null) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/overwrite_history_ring.sv =====
// Top level of the overwrite history ring: stream ports, controller and datapath.
// Depends on ohr_pkg, ohr_ctrl, ohr_datapath (and ohr_ram below it).
//
// A ring of DEPTH slots holding up to DEPTH-1 records; adding to a full ring
// drops the oldest record. A read walks from the newest record toward the
// oldest, one slot per cycle through the single read port of the slot RAM
// while the output is not stalled, for at most min(DEPTH-1, 50) slots.
// The read answer is one result per record (tlast on the final one), or one
// result with found=0 when nothing is returned. New items are taken only
// while no read is in progress; the last result may still wait on the output.
// The slot RAM has no reset and no clearing pass.
module overwrite_history_ring #(
	parameter int DEPTH       = ohr_pkg::DEPTH_DEF,
	parameter int RECORD_BITS = ohr_pkg::RECORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// record_word[63:0], skip_count[68:64], want_count[73:69], room[78:74]
	input  logic [ohr_pkg::IN_TDATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_record[63:0], position[68:64]
	output logic [ohr_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	// found[0]
	output logic                            m_tuser
);

	ohr_pkg::cmd_t    cmd;
	ohr_pkg::status_t status;

	ohr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.op      (s_tuser),
		.status  (status),
		.cmd     (cmd)
	);

	ohr_datapath #(
		.DEPTH      (DEPTH),
		.RECORD_BITS(RECORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.in_data (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// ===== sim/overwrite_history_ring_tb.sv =====
// Testbench for overwrite_history_ring: drives stream items and checks every result
// against an in-bench ring predictor. Directed cases, wrap/overwrite, stalls, random traffic.
// Depends on src/ohr_pkg.sv and src/overwrite_history_ring.sv.
module overwrite_history_ring_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         IDLE_PCT    = 37;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         RING_DEPTH  = ohr_pkg::DEPTH_DEF;
	localparam int         IDX_W       = $clog2(RING_DEPTH);
	localparam int         REC_W       = ohr_pkg::REC_W;
	localparam int         CNT_W       = ohr_pkg::CNT_W;
	localparam int         IN_W        = ohr_pkg::IN_TDATA_W;
	localparam int         OUT_W       = ohr_pkg::OUT_TDATA_W;
	localparam int         STEP_LIMIT  = ohr_pkg::STEP_LIMIT;

	typedef struct {
		bit             found;
		bit [REC_W-1:0] rec;
		bit [CNT_W-1:0] pos;
		bit             last;
	} answer_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	// predicted ring contents
	logic [REC_W-1:0] ring_slots [RING_DEPTH];
	logic [IDX_W-1:0] ring_oldest = '0;
	logic [IDX_W-1:0] ring_next_free = '0;

	answer_t answer_q [$];
	int      errors = 0;
	int      cycle_cnt = 0;
	int      rx_hold = 0;
	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;

	overwrite_history_ring u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// update the ring and queue the answers one accepted item produces
	task automatic ring_apply(input logic [1:0] op, input logic [REC_W-1:0] rec,
			input logic [CNT_W-1:0] skip, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] room);
		logic [IDX_W-1:0] succ;
		logic [IDX_W-1:0] p;
		int               n;
		int               seen;
		int               walked;
		bit               walking;
		answer_t          a;
		succ = ring_next_free + IDX_W'(1);
		case (op)
			ohr_pkg::OP_ADD: begin
				if (succ == ring_oldest)
					ring_oldest = ring_oldest + IDX_W'(1);
				ring_slots[ring_next_free] = rec;
				ring_next_free = succ;
			end
			ohr_pkg::OP_CLEAR: begin
				ring_oldest = ring_next_free;
			end
			ohr_pkg::OP_READ: begin
				n = 0;
				if (ring_oldest != ring_next_free) begin
					p = ring_next_free;
					seen = 0;
					walked = 0;
					walking = 1'b1;
					while (walking) begin
						p = p - IDX_W'(1);
						if (seen >= skip && n < room && n < want) begin
							a.found = 1'b1;
							a.rec = ring_slots[p];
							a.pos = n[CNT_W-1:0];
							a.last = 1'b0;
							answer_q.push_back(a);
							n++;
						end
						seen++;
						walked++;
						walking = p != ring_oldest && walked < STEP_LIMIT
							&& n < room && n < want;
					end
				end
				if (n == 0) begin
					a.found = 1'b0;
					a.rec = '0;
					a.pos = '0;
					a.last = 1'b1;
					answer_q.push_back(a);
				end else begin
					answer_q[answer_q.size() - 1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input logic [REC_W-1:0] rec,
			input logic [CNT_W-1:0] skip, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] room);
		while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, room, want, skip, rec};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ring_apply(op, rec, skip, want, room);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic flag_mismatch(input string what, input logic [REC_W-1:0] exp_v,
			input logic [REC_W-1:0] got_v);
		$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
		errors++;
	endtask

	// result checker and output backpressure
	initial begin
		answer_t a;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, %s %h last %b found %b",
						$time, "actual", m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					a = answer_q.pop_front();
					if (m_tuser !== a.found)
						flag_mismatch("found", REC_W'(a.found), REC_W'(m_tuser));
					if (m_tdata[REC_W-1:0] !== a.rec)
						flag_mismatch("out_record", a.rec, m_tdata[REC_W-1:0]);
					if (m_tdata[REC_W+CNT_W-1:REC_W] !== a.pos)
						flag_mismatch("position", REC_W'(a.pos),
							REC_W'(m_tdata[REC_W+CNT_W-1:REC_W]));
					if (m_tlast !== a.last)
						flag_mismatch("last", REC_W'(a.last), REC_W'(m_tlast));
				end
			end
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	task automatic test_directed();
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd5, 5'd5);
		send_item(OP_UNUSED, '1, '1, '1, '1);
		send_item(ohr_pkg::OP_CLEAR, '0, '0, '0, '0);
		send_item(ohr_pkg::OP_ADD, '0, '0, '0, '0);
		send_item(ohr_pkg::OP_ADD, '1, '1, '1, '1);
		send_item(ohr_pkg::OP_ADD, 64'ha5a5_5a5a_0ff0_f00f, 5'd7, 5'd9, 5'd11);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd0, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd0);
		send_item(ohr_pkg::OP_READ, '0, 5'd3, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_READ, '1, 5'd31, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd2, 5'd1, 5'd1);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd2, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd1, 5'd31, 5'd1);
		send_item(OP_UNUSED, {$urandom, $urandom}, 5'd0, 5'd3, 5'd3);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_CLEAR, '1, '1, '1, '1);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_ADD, 64'h8000_0000_0000_0001, '0, '0, '0);
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd31);
		wait_drained();
	endtask

	// more adds than slots, so the oldest records get overwritten
	task automatic test_wraparound();
		repeat (40)
			send_item(ohr_pkg::OP_ADD, {$urandom, $urandom}, 5'($urandom), 5'($urandom),
				5'($urandom));
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd30, 5'd31, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd29, 5'd5, 5'd31);
		send_item(ohr_pkg::OP_READ, '0, 5'd31, 5'd31, 5'd31);
		wait_drained();
	endtask

	// receiver holds off so a read stalls on the output and later items wait; sender then pauses until all answers are in
	task automatic test_output_stall();
		rx_hold = 250;
		repeat (4) begin
			send_item(ohr_pkg::OP_READ, '0, 5'($urandom_range(0, 3)), 5'd31, 5'd31);
			send_item(ohr_pkg::OP_ADD, {$urandom, $urandom}, '0, '0, '0);
		end
		wait_drained();
		send_item(ohr_pkg::OP_READ, '0, 5'd0, 5'd31, 5'd31);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items, input bit with_idle);
		int sent;
		int burst;
		int r;
		tx_idle_on = with_idle;
		rx_idle_on = with_idle;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 36);
			repeat (burst) begin
				r = $urandom_range(0, 99);
				if (r < 90)
					send_item(ohr_pkg::OP_ADD, {$urandom, $urandom}, 5'($urandom),
						5'($urandom), 5'($urandom));
				else if (r < 94)
					send_item(OP_UNUSED, {$urandom, $urandom}, 5'($urandom), 5'($urandom),
						5'($urandom));
				else if (r < 97)
					send_item(ohr_pkg::OP_CLEAR, {$urandom, $urandom}, 5'($urandom),
						5'($urandom), 5'($urandom));
				else
					send_item(ohr_pkg::OP_READ, {$urandom, $urandom}, 5'($urandom),
						5'($urandom), 5'($urandom));
			end
			sent += burst;
			repeat ($urandom_range(1, 4)) begin
				send_item(ohr_pkg::OP_READ, {$urandom, $urandom},
					$urandom_range(0, 1) ? 5'($urandom_range(0, 4)) : 5'($urandom),
					$urandom_range(0, 2) ? 5'($urandom) : 5'd31,
					$urandom_range(0, 2) ? 5'($urandom) : 5'd31);
				sent++;
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_wraparound();
		test_output_stall();
		test_random_traffic(40, 1'b0);
		test_random_traffic(200, 1'b1);

		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
